// ===== sv/ktt_pkg.sv =====
package ktt_pkg;

	// Opcodes of an input beat.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_APPENDED   = 3'd0;
	localparam logic [2:0] ST_NEW_ROW    = 3'd1;
	localparam logic [2:0] ST_ROW_FULL   = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_ENTRY      = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd5;

	localparam int KEY_W     = 64;
	localparam int WEIGHT_W  = 64;
	localparam int SLOT_OUT_W = 4;
	localparam int CNT_OUT_W  = 5;

	// Job fields are sized for the largest supported table (256 rows, 64 slots).
	localparam int ROW_W  = 8;
	localparam int SLOT_W = 6;
	localparam int CNT_W  = 7;

	// Depth of the job queue between front and back; a power of two.
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic                       opcode;
		logic signed [KEY_W-1:0]    source_key;
		logic signed [KEY_W-1:0]    target_key;
		logic        [WEIGHT_W-1:0] weight_bits;
	} item_t;

	typedef struct packed {
		logic        [2:0]            status;
		logic signed [KEY_W-1:0]      target_out;
		logic        [WEIGHT_W-1:0]   weight_out;
		logic        [SLOT_OUT_W-1:0] slot_index;
		logic        [CNT_OUT_W-1:0]  entry_count;
		logic                         last;
	} result_t;

	// A classified item as handed from the front to the back.
	typedef struct packed {
		logic                       do_write;
		logic                       do_read;
		logic        [2:0]          status;
		logic        [ROW_W-1:0]    row;
		logic        [SLOT_W-1:0]   slot;
		logic        [CNT_W-1:0]    count;
		logic signed [KEY_W-1:0]    target;
		logic        [WEIGHT_W-1:0] weight;
	} job_t;

endpackage

// ===== sv/ktt_front.sv =====
module ktt_front import ktt_pkg::*; #(
	parameter int ROWS  = 16,
	parameter int SLOTS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  push,
	output job_t  push_job,
	input  logic  q_full
);

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int UW = $clog2(ROWS + 1);
	localparam int FW = $clog2(SLOTS + 1);

	typedef enum logic {F_IDLE, F_CLASS} fstate_t;

	fstate_t          state_q;
	item_t            item_q;
	logic [ROWS-1:0]  hit_q;
	logic [KEY_W-1:0] key_q [ROWS];
	logic [FW-1:0]    fill_q [ROWS];
	logic [UW-1:0]    used_q;

	logic            accept;
	logic [ROWS-1:0] hit_d;
	logic [RW-1:0]   hit_row;
	logic            hit_any;
	logic [FW-1:0]   hit_fill;
	logic            open_row;
	logic            bump_row;
	job_t            job;

	assign item_stall = (state_q != F_IDLE);
	assign accept     = item_valid && !item_stall;

	// Key match against every open row, registered on accept.
	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			hit_d[i] = (key_q[i] == item.source_key) && (UW'(i) < used_q);
		end
	end

	// Keys are unique, so an OR of the hit indexes gives the matching row.
	always_comb begin
		hit_row = '0;
		for (int i = 0; i < ROWS; i++) begin
			if (hit_q[i]) begin
				hit_row = hit_row | RW'(i);
			end
		end
	end

	assign hit_any  = |hit_q;
	assign hit_fill = fill_q[hit_row];

	always_comb begin
		job        = '0;
		open_row   = 1'b0;
		bump_row   = 1'b0;
		job.target = item_q.target_key;
		job.weight = item_q.weight_bits;
		if (item_q.opcode == OP_ADD) begin
			if (hit_any) begin
				job.row = ROW_W'(hit_row);
				if (hit_fill >= FW'(SLOTS)) begin
					job.status = ST_ROW_FULL;
					job.count  = CNT_W'(hit_fill);
				end else begin
					job.do_write = 1'b1;
					job.status   = ST_APPENDED;
					job.slot     = SLOT_W'(hit_fill);
					job.count    = CNT_W'(hit_fill) + CNT_W'(1);
					bump_row     = 1'b1;
				end
			end else if (used_q >= UW'(ROWS)) begin
				job.status = ST_TABLE_FULL;
			end else begin
				job.do_write = 1'b1;
				job.status   = ST_NEW_ROW;
				job.row      = ROW_W'(used_q);
				job.count    = CNT_W'(1);
				open_row     = 1'b1;
			end
		end else if (!hit_any || hit_fill == '0) begin
			job.status = ST_NOT_FOUND;
		end else begin
			job.do_read = 1'b1;
			job.status  = ST_ENTRY;
			job.row     = ROW_W'(hit_row);
			job.count   = CNT_W'(hit_fill);
		end
	end

	assign push     = (state_q == F_CLASS) && !q_full;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			used_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					if (push) begin
						state_q <= F_IDLE;
						if (open_row) begin
							used_q <= used_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			hit_q  <= hit_d;
		end
		if (push && open_row) begin
			key_q[used_q[RW-1:0]]  <= item_q.source_key;
			fill_q[used_q[RW-1:0]] <= FW'(1);
		end
		if (push && bump_row) begin
			fill_q[hit_row] <= hit_fill + 1'b1;
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(ROWS))
		else $error("more rows opened than the table holds");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_CLASS) |-> $onehot0(hit_q))
		else $error("source key matched more than one row");

endmodule

// ===== sv/ktt_queue.sv =====
module ktt_queue import ktt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t head
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	job_t          slot_q [Q_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(Q_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== sv/ktt_back.sv =====
module ktt_back import ktt_pkg::*; #(
	parameter int ROWS  = 16,
	parameter int SLOTS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    avail,
	input  job_t    head,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int DEPTH = ROWS * SLOTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = KEY_W + WEIGHT_W;

	typedef enum logic {B_IDLE, B_READ} bstate_t;

	bstate_t         state_q;
	job_t            job_q;
	logic [CNT_W-1:0] j_q;
	logic [EW-1:0]   entry_mem_q [DEPTH];

	logic             rd_v_s1;
	logic [EW-1:0]    rdata_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [CNT_W-1:0] count_s1;
	logic             last_s1;

	result_t res_q;
	logic    res_v_q;

	logic          out_free;
	logic          single;
	logic          start;
	logic          issue;
	logic          rd_last;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign out_free = !res_v_q || !result_stall;
	// Adds and misses produce one result straight from the job.
	assign single   = (state_q == B_IDLE) && avail && !head.do_read && !rd_v_s1 && out_free;
	assign start    = (state_q == B_IDLE) && avail && head.do_read;
	assign pop      = single || start;
	// A read goes out only when its data will have a place to land.
	assign issue    = (state_q == B_READ) && (!rd_v_s1 || out_free);
	assign rd_last  = (CNT_W'(j_q + 1'b1) == job_q.count);

	assign wr_addr = AW'(head.row) * AW'(SLOTS) + AW'(head.slot);
	assign rd_addr = AW'(job_q.row) * AW'(SLOTS) + AW'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			j_q     <= '0;
			rd_v_s1 <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_READ;
						j_q     <= '0;
					end
				end
				B_READ: begin
					if (issue) begin
						j_q <= j_q + 1'b1;
						if (rd_last) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (issue) begin
				rd_v_s1 <= 1'b1;
			end else if (out_free) begin
				rd_v_s1 <= 1'b0;
			end
			if (out_free) begin
				res_v_q <= rd_v_s1 || single;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (single && head.do_write) begin
			entry_mem_q[wr_addr] <= {head.target, head.weight};
		end
		if (issue) begin
			rdata_s1 <= entry_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= head;
		end
		if (issue) begin
			slot_s1  <= SLOT_W'(j_q);
			count_s1 <= job_q.count;
			last_s1  <= rd_last;
		end
		if (out_free) begin
			if (rd_v_s1) begin
				res_q.status      <= ST_ENTRY;
				res_q.target_out  <= rdata_s1[EW-1:WEIGHT_W];
				res_q.weight_out  <= rdata_s1[WEIGHT_W-1:0];
				res_q.slot_index  <= SLOT_OUT_W'(slot_s1);
				res_q.entry_count <= CNT_OUT_W'(count_s1);
				res_q.last        <= last_s1;
			end else if (single) begin
				res_q.status      <= head.status;
				res_q.target_out  <= '0;
				res_q.weight_out  <= '0;
				res_q.slot_index  <= SLOT_OUT_W'(head.slot);
				res_q.entry_count <= CNT_OUT_W'(head.count);
				res_q.last        <= 1'b1;
			end
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 && res_v_q && result_stall) |-> !issue)
		else $error("read issued while read data could not move on");

	a_no_pop_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> !pop)
		else $error("job taken while a row is still being read");

endmodule

// ===== sv/keyed_transition_table_top.sv =====
// An add answers once its job has passed the front's item register, the queue and the
// output register; a query's first entry also passes the back's job and read registers.
// The front takes no new beat until it has pushed the one before; the back gives one result per
// cycle while result_stall is low, and a query holds it until its last read is issued.
// Reset (arst_n low, asynchronous) empties the table and the queue; the stores hold no
// reset value and nothing is read from them until it has been written.
module keyed_transition_table_top import ktt_pkg::*; #(
	parameter int ROWS  = 16,
	parameter int SLOTS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// The front holds the row keys, the row fill counts and the number of open rows.
	// It matches the source key against every open row in the cycle the beat is taken,
	// then decides in the next cycle what the item does; it updates its row state when it
	// pushes the job, so the following beat already sees the new row or the new fill count.
	job_t push_job;
	logic push;
	logic q_full;

	// The queue between the two halves lets the front classify the next beat while
	// the back is still streaming out the entries of an earlier query.
	job_t head;
	logic avail;
	logic pop;

	ktt_front #(
		.ROWS  (ROWS),
		.SLOTS (SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	ktt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	// The back owns the entry memory. It writes appended entries and reads a queried row
	// one slot per cycle (while its read data can move on) through a registered read port;
	// an output register keeps the result so a waiting result does not hold up the next read.
	ktt_back #(
		.ROWS  (ROWS),
		.SLOTS (SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (avail),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
